// ----- rtl/core/hsf_pkg.sv -----
// Package: shared types, constants and saturating helpers for the high shelf filter.
package hsf_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int NUM_REGS         = 8;
  localparam int REG_IDX_W        = 3;
  localparam int COEF_W           = 64;
  localparam int STEP_W           = 6;

  localparam logic signed [COEF_W-1:0] Q_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] Q_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  typedef enum logic [REG_IDX_W-1:0] {
    REG_INV_TAN_K     = 3'd0,
    REG_NORM_GAIN     = 3'd1,
    REG_LP_FEEDBACK   = 3'd2,
    REG_LP_INPUT_GAIN = 3'd3,
    REG_BIQUAD_A2     = 3'd4,
    REG_INV_TAN_SQ    = 3'd5,
    REG_BIQUAD_A1     = 3'd6,
    REG_SHELF_GAIN    = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_MULWAIT,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_ADD,
    OP_NEG,
    OP_END
  } op_t;

  typedef enum logic [2:0] {
    DST_T0,
    DST_T1,
    DST_T2,
    DST_LF,
    DST_L0,
    DST_HF,
    DST_H0
  } dst_t;

  typedef struct packed {
    logic                     done;
    logic signed [COEF_W-1:0] prod;
  } qmul_rsp_t;

  function automatic logic signed [COEF_W-1:0] sat_add(
    input logic signed [COEF_W-1:0] a,
    input logic signed [COEF_W-1:0] b
  );
    logic signed [COEF_W:0] s;
    s = {a[COEF_W-1], a} + {b[COEF_W-1], b};
    if (s[COEF_W] != s[COEF_W-1]) begin
      return s[COEF_W] ? Q_MIN : Q_MAX;
    end
    return s[COEF_W-1:0];
  endfunction

  function automatic logic signed [COEF_W-1:0] sat_neg(input logic signed [COEF_W-1:0] a);
    if (a == Q_MIN) begin
      return Q_MAX;
    end
    return -a;
  endfunction

endpackage

// ----- rtl/core/hsf_if.sv -----
// Interfaces: sample input channel and filtered sample output channel.
interface hsf_in_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;
  logic                           clear_state;

  modport source (output valid, output sample_in, output clear_state, input ready);
  modport sink   (input valid, input sample_in, input clear_state, output ready);
endinterface

interface hsf_out_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// ----- rtl/core/hsf_qmul.sv -----
// Iterative Q31.32 multiplier: four 32x32 partial products, round half away, saturate.
module hsf_qmul
  import hsf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [COEF_W-1:0] a,
  input  logic signed [COEF_W-1:0] b,
  output qmul_rsp_t                rsp
);

  localparam int HALF_W = COEF_W / 2;
  localparam int ACC_W  = 2 * COEF_W;

  logic [COEF_W-1:0] mx, my;
  logic              neg;
  logic [ACC_W-1:0]  acc;
  logic [COEF_W-1:0] prod;
  logic [1:0]        pidx;
  logic [2:0]        cnt;
  logic              busy;
  logic              done;
  logic signed [COEF_W-1:0] result;

  logic [HALF_W-1:0] xsel, ysel;
  logic [ACC_W-1:0]  prod_sh;
  logic [COEF_W-1:0] r;
  logic signed [COEF_W-1:0] sat_val;

  assign xsel = cnt[1] ? mx[COEF_W-1:HALF_W] : mx[HALF_W-1:0];
  assign ysel = cnt[0] ? my[COEF_W-1:HALF_W] : my[HALF_W-1:0];

  always_comb begin
    case (pidx)
      2'd0:    prod_sh = {{COEF_W{1'b0}}, prod};
      2'd3:    prod_sh = {prod, {COEF_W{1'b0}}};
      default: prod_sh = {{HALF_W{1'b0}}, prod, {HALF_W{1'b0}}};
    endcase
  end

  // Rounding constant is preloaded into acc, so only sign restore and saturation are left here
  always_comb begin
    r = acc[COEF_W+HALF_W-1:HALF_W];
    if (acc[ACC_W-1:COEF_W+HALF_W] != '0) begin
      sat_val = neg ? Q_MIN : Q_MAX;
    end else if (neg) begin
      sat_val = r[COEF_W-1] ? Q_MIN : -$signed(r);
    end else begin
      sat_val = r[COEF_W-1] ? Q_MAX : $signed(r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd5) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mx  <= a[COEF_W-1] ? (~a + COEF_W'(1)) : a;
      my  <= b[COEF_W-1] ? (~b + COEF_W'(1)) : b;
      neg <= a[COEF_W-1] ^ b[COEF_W-1];
      acc <= ACC_W'(1) << (HALF_W - 1);
    end else if (busy) begin
      if (cnt <= 3'd3) begin
        prod <= COEF_W'(xsel) * COEF_W'(ysel);
        pidx <= cnt[1:0];
      end
      if (cnt >= 3'd1 && cnt <= 3'd4) begin
        acc <= acc + prod_sh;
      end
      if (cnt == 3'd5) begin
        result <= sat_val;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.prod = result;

endmodule

// ----- rtl/core/high_shelf_filter_third_order_top.sv -----
// Top level: third-order high shelf filter with a microcoded sequencer over one multiplier.
//
//  channel    dir  payload                      handshake
//  in_stream  in   sample_in[SW], clear_state   valid/ready
//  out_stream out  sample_out[SW]               valid/ready
//  cfg        in   cfg_idx[3], cfg_data[64]     cfg_wen, no back-pressure
//
// For each sample the sequencer runs 17 products (four 32x32 passes through the one
// multiplier plus round and saturate) and 16 adds and negations, then loads the output
// register. in_stream.ready is high only while the sequencer is idle; the output register
// lets the next beat in while a result still waits, and a stalled sink holds the
// sequencer at its last step. Synchronous reset clears coefficients, filter state and
// control.
module high_shelf_filter_third_order_top
  import hsf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  hsf_in_if.sink               in_stream,
  hsf_out_if.source            out_stream,
  input  logic                 cfg_wen,
  input  logic [REG_IDX_W-1:0] cfg_idx,
  input  logic [COEF_W-1:0]    cfg_data
);

  // Sample grid to Q31.32 and back
  localparam int SH = 33 - SAMPLE_WIDTH;
  localparam logic signed [COEF_W-1:0] ROUND_HALF = COEF_W'(1) << (SH - 1);
  localparam logic signed [COEF_W-1:0] SMAX = (COEF_W'(1) << (SAMPLE_WIDTH - 1)) - COEF_W'(1);
  localparam logic signed [COEF_W-1:0] SMIN = -SMAX - COEF_W'(1);

  // Coefficient registers
  logic signed [COEF_W-1:0] coef [NUM_REGS];

  // Filter state
  logic signed [SAMPLE_WIDTH-1:0] prev_input;
  logic signed [SAMPLE_WIDTH-1:0] cur_sample;
  logic signed [COEF_W-1:0] low_first, low_d0, low_d1;
  logic signed [COEF_W-1:0] high_first, high_d0, high_d1;

  // Working registers
  logic signed [COEF_W-1:0] t0, t1, t2, lf, l0, hf, h0;

  // Sequencer
  state_t            state, state_next;
  logic [STEP_W-1:0] step;
  op_t               op_kind;
  dst_t              dst;
  logic signed [COEF_W-1:0] opa, opb, wb_data;
  logic              mul_start, wb_en, in_take, out_load;
  qmul_rsp_t         mul_rsp;

  logic                           out_valid;
  logic signed [SAMPLE_WIDTH-1:0] out_sample;

  logic signed [COEF_W-1:0] x_q, xp_q, k_neg, ksq2_neg;
  logic signed [COEF_W-1:0] y_round, y_shift, y_clamp;

  assign x_q  = $signed({{(COEF_W-SAMPLE_WIDTH){cur_sample[SAMPLE_WIDTH-1]}}, cur_sample}) <<< SH;
  assign xp_q = $signed({{(COEF_W-SAMPLE_WIDTH){prev_input[SAMPLE_WIDTH-1]}}, prev_input}) <<< SH;

  assign k_neg    = sat_neg(coef[REG_INV_TAN_K]);
  assign ksq2_neg = sat_neg(sat_add(coef[REG_INV_TAN_SQ], coef[REG_INV_TAN_SQ]));

  // Microprogram: one operation per step, operands and destination fixed by the step
  always_comb begin
    op_kind = OP_END;
    opa     = t0;
    opb     = t1;
    dst     = DST_T0;
    case (step)
      // low path, first-order section
      6'd0:  begin op_kind = OP_MUL; opa = coef[REG_LP_FEEDBACK];   opb = low_first; end
      6'd1:  begin op_kind = OP_ADD; opa = xp_q; opb = x_q; dst = DST_T1; end
      6'd2:  begin op_kind = OP_MUL; opa = coef[REG_LP_INPUT_GAIN]; opb = t1; dst = DST_T1; end
      6'd3:  begin op_kind = OP_ADD; opa = t0; opb = t1; dst = DST_LF; end
      // low path, second-order feedback
      6'd4:  begin op_kind = OP_MUL; opa = coef[REG_BIQUAD_A2]; opb = low_d1; end
      6'd5:  begin op_kind = OP_MUL; opa = coef[REG_BIQUAD_A1]; opb = low_d0; dst = DST_T1; end
      6'd6:  begin op_kind = OP_ADD; opa = t0; opb = t1; end
      6'd7:  begin op_kind = OP_MUL; opa = coef[REG_NORM_GAIN]; opb = t0; end
      6'd8:  begin op_kind = OP_NEG; opa = t0; end
      6'd9:  begin op_kind = OP_ADD; opa = lf; opb = t0; dst = DST_L0; end
      // high path, first-order section
      6'd10: begin op_kind = OP_MUL; opa = coef[REG_LP_FEEDBACK]; opb = high_first; end
      6'd11: begin op_kind = OP_MUL; opa = coef[REG_INV_TAN_K]; opb = x_q; dst = DST_T1; end
      6'd12: begin op_kind = OP_MUL; opa = k_neg; opb = xp_q; dst = DST_T2; end
      6'd13: begin op_kind = OP_ADD; opa = t1; opb = t2; dst = DST_T1; end
      6'd14: begin op_kind = OP_MUL; opa = coef[REG_LP_INPUT_GAIN]; opb = t1; dst = DST_T1; end
      6'd15: begin op_kind = OP_ADD; opa = t0; opb = t1; dst = DST_HF; end
      // high path, second-order feedback
      6'd16: begin op_kind = OP_MUL; opa = coef[REG_BIQUAD_A2]; opb = high_d1; end
      6'd17: begin op_kind = OP_MUL; opa = coef[REG_BIQUAD_A1]; opb = high_d0; dst = DST_T1; end
      6'd18: begin op_kind = OP_ADD; opa = t0; opb = t1; end
      6'd19: begin op_kind = OP_MUL; opa = coef[REG_NORM_GAIN]; opb = t0; end
      6'd20: begin op_kind = OP_NEG; opa = t0; end
      6'd21: begin op_kind = OP_ADD; opa = hf; opb = t0; dst = DST_H0; end
      // low numerator 1,2,1
      6'd22: begin op_kind = OP_ADD; opa = low_d0; opb = low_d0; end
      6'd23: begin op_kind = OP_ADD; opa = l0; opb = t0; end
      6'd24: begin op_kind = OP_ADD; opa = low_d1; opb = t0; end
      // high numerator k2,-2k2,k2
      6'd25: begin op_kind = OP_MUL; opa = coef[REG_INV_TAN_SQ]; opb = h0; dst = DST_T1; end
      6'd26: begin op_kind = OP_MUL; opa = ksq2_neg; opb = high_d0; dst = DST_T2; end
      6'd27: begin op_kind = OP_ADD; opa = t1; opb = t2; dst = DST_T1; end
      6'd28: begin op_kind = OP_MUL; opa = coef[REG_INV_TAN_SQ]; opb = high_d1; dst = DST_T2; end
      6'd29: begin op_kind = OP_ADD; opa = t1; opb = t2; dst = DST_T1; end
      // shelf mix and normalise
      6'd30: begin op_kind = OP_MUL; opa = coef[REG_SHELF_GAIN]; opb = t1; dst = DST_T1; end
      6'd31: begin op_kind = OP_ADD; opa = t0; opb = t1; end
      6'd32: begin op_kind = OP_MUL; opa = coef[REG_NORM_GAIN]; opb = t0; end
      default: op_kind = OP_END;
    endcase
  end

  always_comb begin
    case (op_kind)
      OP_MUL:  wb_data = mul_rsp.prod;
      OP_NEG:  wb_data = sat_neg(opa);
      default: wb_data = sat_add(opa, opb);
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_stream.valid) state_next = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (op_kind == OP_END) state_next = ST_FINISH;
        else if (op_kind == OP_MUL) state_next = ST_MULWAIT;
      end
      ST_MULWAIT: begin
        if (mul_rsp.done) state_next = ST_ISSUE;
      end
      ST_FINISH: begin
        if (!out_valid || out_stream.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_take   = 1'b0;
    mul_start = 1'b0;
    wb_en     = 1'b0;
    out_load  = 1'b0;
    case (state)
      ST_IDLE:    in_take = in_stream.valid;
      ST_ISSUE: begin
        mul_start = (op_kind == OP_MUL);
        wb_en     = (op_kind == OP_ADD) || (op_kind == OP_NEG);
      end
      ST_MULWAIT: wb_en = mul_rsp.done;
      ST_FINISH:  out_load = !out_valid || out_stream.ready;
      default: ;
    endcase
  end

  assign in_stream.ready = (state == ST_IDLE);

  hsf_qmul u_qmul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (opa),
    .b     (opb),
    .rsp   (mul_rsp)
  );

  // Round half up to the sample grid, then clamp
  assign y_round = sat_add(t0, ROUND_HALF);
  assign y_shift = y_round >>> SH;
  assign y_clamp = (y_shift > SMAX) ? SMAX : ((y_shift < SMIN) ? SMIN : y_shift);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (in_take) begin
        step <= '0;
      end else if (wb_en) begin
        step <= step + STEP_W'(1);
      end
    end
  end

  // Coefficients: reset to zero, written one at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        coef[i] <= '0;
      end
    end else if (cfg_wen) begin
      coef[cfg_idx] <= $signed(cfg_data);
    end
  end

  // Filter state: clear on reset or on a flagged beat, advance when the result is loaded into the output register
  always_ff @(posedge clk) begin
    if (rst || (in_take && in_stream.clear_state)) begin
      prev_input <= '0;
      low_first  <= '0;
      low_d0     <= '0;
      low_d1     <= '0;
      high_first <= '0;
      high_d0    <= '0;
      high_d1    <= '0;
    end else if (out_load) begin
      prev_input <= cur_sample;
      low_first  <= lf;
      low_d1     <= low_d0;
      low_d0     <= l0;
      high_first <= hf;
      high_d1    <= high_d0;
      high_d0    <= h0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cur_sample <= in_stream.sample_in;
    end
    if (wb_en) begin
      case (dst)
        DST_T0:  t0 <= wb_data;
        DST_T1:  t1 <= wb_data;
        DST_T2:  t2 <= wb_data;
        DST_LF:  lf <= wb_data;
        DST_L0:  l0 <= wb_data;
        DST_HF:  hf <= wb_data;
        DST_H0:  h0 <= wb_data;
        default: t0 <= wb_data;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_stream.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample <= y_clamp[SAMPLE_WIDTH-1:0];
    end
  end

  assign out_stream.valid      = out_valid;
  assign out_stream.sample_out = out_sample;

endmodule

// ----- rtl/core/hsf_checker.sv -----
// Checker: port-level assertions on the filter top, attached by bind.
module hsf_checker
  import hsf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SAMPLE_WIDTH-1:0] sample_out
);

  // the block is busy right after a beat is taken
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while sequencer busy");

  // no result can appear on the cycle after an input beat
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("output beat too soon after input beat");

  // a waiting output holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(sample_out)))
    else $error("output beat dropped or changed while stalled");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind high_shelf_filter_third_order_top hsf_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_hsf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_stream.valid),
  .in_ready   (in_stream.ready),
  .out_valid  (out_stream.valid),
  .out_ready  (out_stream.ready),
  .sample_out (out_stream.sample_out)
);
